/* hw/rtl/sap_pkg.sv */
// Shared types and constants of the sweep-and-prune broad-phase unit.
package sap_pkg;

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_t;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;

  // pair results per sweep and the width of their counter
  localparam int RESULT_LIMIT = 64;
  localparam int PCNT_W       = 7;

  // register index of the pause flag
  localparam logic REG_PAUSED = 1'b0;

  // kind of result loaded into the output register
  typedef enum logic [2:0] {
    RES_DONE    = 3'd0,
    RES_REFUSED = 3'd1,
    RES_BAD_ID  = 3'd2,
    RES_ADDED   = 3'd3,
    RES_FINAL   = 3'd4
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic lat;
    logic clr_init;
    logic clr_wr;
    logic add_wr0;
    logic add_wr1;
    logic k_zero;
    logic sweep_init;
    logic next_axis;
    logic upd_rd;
    logic upd_wr;
    logic srt_key_rd;
    logic key_lat;
    logic srt_rd;
    logic srt_put_key;
    logic srt_shift;
    logic ovl_rd;
    logic ovl_upd;
    logic push;
    logic out_load;
    res_t res;
  } sap_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic k_end;
    logic s_zero;
    logic ge;
    logic toggle;
    logic found;
    logic clr_done;
    logic add_refuse;
    logic bad_id;
    logic out_free;
    logic pend_v;
    logic axis_y;
  } sap_stat_t;

endpackage

/* hw/rtl/sap_ctrl.sv */
// Controller state machine of the sweep-and-prune unit.
module sap_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_stall,
  input  sap_pkg::sap_stat_t st,
  output sap_pkg::sap_ctl_t  ctl
);
  import sap_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_RST_CLR  = 17'h00002,
    S_CLR      = 17'h00004,
    S_ADD_CHK  = 17'h00008,
    S_ADD0     = 17'h00010,
    S_ADD1     = 17'h00020,
    S_UPD_CHK  = 17'h00040,
    S_UPD_RD   = 17'h00080,
    S_UPD_WR   = 17'h00100,
    S_SRT_KEY  = 17'h00200,
    S_SRT_KEYW = 17'h00400,
    S_SRT_RD   = 17'h00800,
    S_SRT_CMP  = 17'h01000,
    S_SRT_OVL  = 17'h02000,
    S_SRT_PUSH = 17'h04000,
    S_FIN      = 17'h08000,
    S_RESP     = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;
  logic   acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && (state_r == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLR;
      res_r   <= RES_DONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    ctl       = '0;
    ctl.res   = res_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          ctl.lat = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_CLEAR: begin
              ctl.clr_init = 1'b1;
              state_nxt    = S_CLR;
            end
            CMD_ADD:    state_nxt = S_ADD_CHK;
            CMD_UPDATE: begin
              ctl.k_zero = 1'b1;
              state_nxt  = S_UPD_CHK;
            end
            CMD_SWEEP: begin
              ctl.sweep_init = 1'b1;
              state_nxt      = S_SRT_KEY;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RST_CLR: begin
        ctl.clr_wr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_CLR: begin
        ctl.clr_wr = 1'b1;
        if (st.clr_done) begin
          res_nxt   = RES_DONE;
          state_nxt = S_RESP;
        end
      end
      S_ADD_CHK: begin
        if (st.add_refuse) begin
          res_nxt   = RES_REFUSED;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_ADD0;
        end
      end
      S_ADD0: begin
        ctl.add_wr0 = 1'b1;
        state_nxt   = S_ADD1;
      end
      S_ADD1: begin
        ctl.add_wr1 = 1'b1;
        res_nxt     = RES_ADDED;
        state_nxt   = S_RESP;
      end
      S_UPD_CHK: begin
        if (st.bad_id) begin
          res_nxt   = RES_BAD_ID;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        if (st.k_end) begin
          res_nxt   = RES_DONE;
          state_nxt = S_RESP;
        end else begin
          ctl.upd_rd = 1'b1;
          state_nxt  = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        ctl.upd_wr = 1'b1;
        state_nxt  = S_UPD_RD;
      end
      // insertion sort: fetch the next key
      S_SRT_KEY: begin
        if (st.k_end) begin
          if (st.axis_y) begin
            state_nxt = S_FIN;
          end else begin
            ctl.next_axis = 1'b1;
          end
        end else begin
          ctl.srt_key_rd = 1'b1;
          state_nxt      = S_SRT_KEYW;
        end
      end
      S_SRT_KEYW: begin
        ctl.key_lat = 1'b1;
        state_nxt   = S_SRT_RD;
      end
      S_SRT_RD: begin
        if (st.s_zero) begin
          ctl.srt_put_key = 1'b1;
          state_nxt       = S_SRT_KEY;
        end else begin
          ctl.srt_rd = 1'b1;
          state_nxt  = S_SRT_CMP;
        end
      end
      S_SRT_CMP: begin
        if (!st.ge) begin
          ctl.srt_put_key = 1'b1;
          state_nxt       = S_SRT_KEY;
        end else if (st.toggle) begin
          ctl.ovl_rd = 1'b1;
          state_nxt  = S_SRT_OVL;
        end else begin
          ctl.srt_shift = 1'b1;
          state_nxt     = S_SRT_RD;
        end
      end
      S_SRT_OVL: begin
        ctl.srt_shift = 1'b1;
        ctl.ovl_upd   = 1'b1;
        state_nxt     = S_SRT_PUSH;
      end
      // park a new pair; the one parked before goes out first
      S_SRT_PUSH: begin
        if (!st.found) begin
          state_nxt = S_SRT_RD;
        end else if (!st.pend_v || st.out_free) begin
          ctl.push  = 1'b1;
          state_nxt = S_SRT_RD;
        end
      end
      S_FIN: begin
        ctl.res = RES_FINAL;
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/sap_dpath.sv */
// Datapath of the sweep-and-prune unit: endpoint lists, overlap rows, counters, output.
module sap_dpath #(
  parameter int MAX_BOXES   = 8,
  parameter int COORD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sap_pkg::sap_ctl_t  ctl,
  output sap_pkg::sap_stat_t st,
  input  logic               paused,
  input  logic [2:0]         in_particle_id,
  input  logic [15:0]        in_x_low,
  input  logic [15:0]        in_x_high,
  input  logic [15:0]        in_y_low,
  input  logic [15:0]        in_y_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_assigned_id,
  output logic               out_pair_valid,
  output logic [2:0]         out_first_id,
  output logic [2:0]         out_second_id,
  output logic               out_overflow,
  output logic               out_last
);
  import sap_pkg::*;

  localparam int IW    = $clog2(MAX_BOXES);
  localparam int DEPTH = 2 * MAX_BOXES;
  localparam int AW    = IW + 1;
  localparam int KW    = $clog2(DEPTH + 1);
  localparam int CNW   = $clog2(MAX_BOXES + 1);
  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW + 1 + IW;
  localparam logic signed [32:0] CHI = 33'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [32:0] CLO = -CHI - 33'sd1;

  // sign extend and saturate a 16-bit bound to the coordinate width
  function automatic logic [CW-1:0] sat(input logic [15:0] raw);
    logic signed [32:0] v;
    v = 33'(signed'(raw));
    if (v > CHI) v = CHI;
    if (v < CLO) v = CLO;
    return v[CW-1:0];
  endfunction

  // endpoint lists and overlap rows
  logic [EW-1:0]        xmem [DEPTH];
  logic [EW-1:0]        ymem [DEPTH];
  logic [MAX_BOXES-1:0] ovx  [MAX_BOXES];
  logic [MAX_BOXES-1:0] ovy  [MAX_BOXES];

  logic [EW-1:0]        x_rd_r, y_rd_r, key_r;
  logic [MAX_BOXES-1:0] xr_r, yr_r;
  logic [2:0]           pid_r;
  logic [CW-1:0]        xl_r, xh_r, yl_r, yh_r;
  logic [CNW-1:0]       cnt_r;
  logic [KW-1:0]        k_r;
  logic [AW-1:0]        s_r;
  logic                 axis_r;
  logic [IW-1:0]        row_r;
  logic [PCNT_W-1:0]    pcnt_r;
  logic                 over_r, np_r, pend_v_r;
  logic [IW-1:0]        npa_r, npb_r, pa_r, pb_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [2:0]           out_assigned_id_r, out_first_id_r, out_second_id_r;
  logic                 out_pair_valid_r, out_overflow_r, out_last_r;

  logic [EW-1:0]        act_rd;
  logic signed [CW-1:0] key_val, oth_val;
  logic                 key_min, oth_min;
  logic [IW-1:0]        key_own, oth_own, ov_a, ov_b, own_new;
  logic                 x_we, y_we, rd_en;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        x_wd, y_wd;
  logic                 ovx_we, ovy_we;
  logic [IW-1:0]        ov_waddr;
  logic [MAX_BOXES-1:0] ovx_wd, ovy_wd;
  logic                 newpair, ld;
  logic [1:0]           o_status;
  logic [2:0]           o_id, o_first, o_second;
  logic                 o_pair, o_ovf, o_last;

  // fields of the key and of the fetched neighbor
  assign act_rd  = axis_r ? y_rd_r : x_rd_r;
  assign key_val = signed'(key_r[EW-1 -: CW]);
  assign key_min = key_r[IW];
  assign key_own = key_r[IW-1:0];
  assign oth_val = signed'(act_rd[EW-1 -: CW]);
  assign oth_min = act_rd[IW];
  assign oth_own = act_rd[IW-1:0];
  assign ov_a    = (key_own < oth_own) ? key_own : oth_own;
  assign ov_b    = (key_own < oth_own) ? oth_own : key_own;
  assign own_new = cnt_r[IW-1:0];

  // a min passing a foreign max on this axis; pair is new when the other axis agrees
  assign newpair = key_min && (axis_r ? xr_r[ov_b] : yr_r[ov_b]);

  // list write and read port selection
  always_comb begin
    x_we  = 1'b0;
    y_we  = 1'b0;
    waddr = s_r;
    x_wd  = key_r;
    y_wd  = key_r;
    rd_en = ctl.upd_rd || ctl.srt_key_rd || ctl.srt_rd;
    raddr = ctl.srt_rd ? (s_r - AW'(1)) : k_r[AW-1:0];
    if (ctl.add_wr0 || ctl.add_wr1) begin
      x_we  = 1'b1;
      y_we  = 1'b1;
      waddr = {own_new, ctl.add_wr1};
      x_wd  = ctl.add_wr1 ? {xh_r, 1'b0, own_new} : {xl_r, 1'b1, own_new};
      y_wd  = ctl.add_wr1 ? {yh_r, 1'b0, own_new} : {yl_r, 1'b1, own_new};
    end else if (ctl.upd_wr) begin
      waddr = k_r[AW-1:0];
      x_we  = (32'(x_rd_r[IW-1:0]) == 32'(pid_r));
      y_we  = (32'(y_rd_r[IW-1:0]) == 32'(pid_r));
      x_wd  = {(x_rd_r[IW] ? xl_r : xh_r), x_rd_r[IW:0]};
      y_wd  = {(y_rd_r[IW] ? yl_r : yh_r), y_rd_r[IW:0]};
    end else if (ctl.srt_put_key || ctl.srt_shift) begin
      x_we = !axis_r;
      y_we = axis_r;
      x_wd = ctl.srt_shift ? act_rd : key_r;
      y_wd = ctl.srt_shift ? act_rd : key_r;
    end
  end

  // overlap row write selection
  always_comb begin
    ovx_we   = 1'b0;
    ovy_we   = 1'b0;
    ov_waddr = ov_a;
    ovx_wd   = xr_r;
    ovy_wd   = yr_r;
    if (ctl.clr_wr) begin
      ovx_we   = 1'b1;
      ovy_we   = 1'b1;
      ov_waddr = row_r;
      ovx_wd   = '0;
      ovy_wd   = '0;
    end else if (ctl.ovl_upd) begin
      ovx_we = !axis_r;
      ovy_we = axis_r;
      ovx_wd[ov_b] = key_min;
      ovy_wd[ov_b] = key_min;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (x_we) xmem[waddr] <= x_wd;
    if (y_we) ymem[waddr] <= y_wd;
    if (rd_en) begin
      x_rd_r <= xmem[raddr];
      y_rd_r <= ymem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ovx_we) ovx[ov_waddr] <= ovx_wd;
    if (ovy_we) ovy[ov_waddr] <= ovy_wd;
    if (ctl.ovl_rd) begin
      xr_r <= ovx[ov_a];
      yr_r <= ovy[ov_a];
    end
  end

  // latched transaction fields and sort key
  always_ff @(posedge clk) begin
    if (ctl.lat) begin
      pid_r <= in_particle_id;
      xl_r  <= sat(in_x_low);
      xh_r  <= sat(in_x_high);
      yl_r  <= sat(in_y_low);
      yh_r  <= sat(in_y_high);
    end
    if (ctl.key_lat) key_r <= act_rd;
    if (ctl.ovl_upd) begin
      npa_r <= key_own;
      npb_r <= oth_own;
    end
    if (ctl.push) begin
      pa_r <= npa_r;
      pb_r <= npb_r;
    end
  end

  // counters and sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      row_r    <= '0;
      k_r      <= '0;
      s_r      <= '0;
      axis_r   <= 1'b0;
      pcnt_r   <= '0;
      over_r   <= 1'b0;
      np_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (ctl.clr_init) begin
        cnt_r <= '0;
        row_r <= '0;
      end
      if (ctl.clr_wr) row_r <= row_r + IW'(1);
      if (ctl.out_load && ctl.res == RES_ADDED) cnt_r <= cnt_r + CNW'(1);
      if (ctl.k_zero) k_r <= '0;
      if (ctl.sweep_init) begin
        k_r      <= KW'(1);
        axis_r   <= 1'b0;
        pcnt_r   <= '0;
        over_r   <= 1'b0;
        pend_v_r <= 1'b0;
      end
      if (ctl.next_axis) begin
        k_r    <= KW'(1);
        axis_r <= 1'b1;
      end
      if (ctl.upd_wr || ctl.srt_put_key) k_r <= k_r + KW'(1);
      if (ctl.srt_key_rd) s_r <= k_r[AW-1:0];
      if (ctl.srt_shift) s_r <= s_r - AW'(1);
      if (ctl.ovl_upd) begin
        np_r <= newpair;
        if (newpair && pcnt_r == PCNT_W'(RESULT_LIMIT)) over_r <= 1'b1;
      end
      if (ctl.push) begin
        pcnt_r   <= pcnt_r + PCNT_W'(1);
        pend_v_r <= 1'b1;
      end
    end
  end

  // result selection
  always_comb begin
    o_status = ST_DONE;
    o_id     = 3'd0;
    o_pair   = 1'b0;
    o_first  = 3'd0;
    o_second = 3'd0;
    o_ovf    = 1'b0;
    o_last   = 1'b1;
    if (ctl.push) begin
      o_pair   = 1'b1;
      o_first  = 3'(pa_r);
      o_second = 3'(pb_r);
      o_last   = 1'b0;
    end else begin
      case (ctl.res)
        RES_REFUSED: o_status = ST_REFUSED;
        RES_BAD_ID:  o_status = ST_BAD_ID;
        RES_ADDED:   o_id = 3'(cnt_r);
        RES_FINAL: begin
          if (pend_v_r) begin
            o_pair   = 1'b1;
            o_first  = 3'(pa_r);
            o_second = 3'(pb_r);
            o_ovf    = over_r;
          end
        end
        default: o_status = ST_DONE;
      endcase
    end
  end

  assign ld = ctl.out_load || (ctl.push && pend_v_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r      <= o_status;
      out_assigned_id_r <= o_id;
      out_pair_valid_r  <= o_pair;
      out_first_id_r    <= o_first;
      out_second_id_r   <= o_second;
      out_overflow_r    <= o_ovf;
      out_last_r        <= o_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_assigned_id_r;
  assign out_pair_valid  = out_pair_valid_r;
  assign out_first_id    = out_first_id_r;
  assign out_second_id   = out_second_id_r;
  assign out_overflow    = out_overflow_r;
  assign out_last        = out_last_r;

  // status to the controller
  always_comb begin
    st.k_end      = (32'(k_r) >= 32'({cnt_r, 1'b0}));
    st.s_zero     = (s_r == '0);
    st.ge         = (oth_val >= key_val);
    st.toggle     = (oth_own != key_own) && (oth_min != key_min);
    st.found      = np_r && (pcnt_r < PCNT_W'(RESULT_LIMIT));
    st.clr_done   = (row_r == IW'(MAX_BOXES - 1));
    st.add_refuse = paused || (cnt_r == CNW'(MAX_BOXES));
    st.bad_id     = (32'(pid_r) >= 32'(cnt_r));
    st.out_free   = !out_valid_r || !out_stall;
    st.pend_v     = pend_v_r;
    st.axis_y     = axis_r;
  end

endmodule

/* hw/rtl/sweep_and_prune_broadphase_unit.sv */
// Top level of the sweep-and-prune broad-phase unit: register port, controller, datapath.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | cmd, particle_id, x/y low/high bounds
//   out_    | output    | out_valid / out_stall  | status, ids, pair_valid, overflow, last
//   config  | input     | psel/penable/pwrite    | paddr, pwdata, prdata (paused flag)
//
// A sweep fetches each key and compares it with its neighbours toward the list head;
// a swap that touches an overlap row also updates that row. The x axis is swept, then
// the y axis, then the sweep finishes. Each endpoint list has a single read port.
// After reset, overlap rows are cleared one per cycle while in_stall stays high.
// A stalled output holds the sweep when a second pair must leave, and at the final result.
module sweep_and_prune_broadphase_unit #(
  parameter int MAX_BOXES   = 8,
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_particle_id,
  input  logic [15:0] in_x_low,
  input  logic [15:0] in_x_high,
  input  logic [15:0] in_y_low,
  input  logic [15:0] in_y_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_assigned_id,
  output logic        out_pair_valid,
  output logic [2:0]  out_first_id,
  output logic [2:0]  out_second_id,
  output logic        out_overflow,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sap_pkg::*;

  sap_ctl_t  ctl;
  sap_stat_t st;
  logic      paused_r;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_PAUSED) begin
      paused_r <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_PAUSED) ? {31'd0, paused_r} : 32'd0;

  sap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  sap_dpath #(
    .MAX_BOXES   (MAX_BOXES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .st              (st),
    .paused          (paused_r),
    .in_particle_id  (in_particle_id),
    .in_x_low        (in_x_low),
    .in_x_high       (in_x_high),
    .in_y_low        (in_y_low),
    .in_y_high       (in_y_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_assigned_id (out_assigned_id),
    .out_pair_valid  (out_pair_valid),
    .out_first_id    (out_first_id),
    .out_second_id   (out_second_id),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

  // an accepted transaction always makes the unit busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit not busy after accepting a transaction");

  // pair results carry no add status or id
  a_pair_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pair_valid |-> out_status == ST_DONE && out_assigned_id == 3'd0)
    else $error("pair result with add fields set");

  // overflow only on the final pair of a sweep
  a_overflow_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last && out_pair_valid)
    else $error("overflow outside the final pair result");

endmodule

/* test/tb_sweep_and_prune_broadphase_unit.sv */
// Testbench of the sweep-and-prune broad-phase unit: directed table, then random commands.
`timescale 1ns / 1ps

module tb_sweep_and_prune_broadphase_unit;
  import sap_pkg::*;

  localparam int NBOX = 8;
  localparam int NEND = 2 * NBOX;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] assigned_id;
    logic       pair_valid;
    logic [2:0] first_id;
    logic [2:0] second_id;
    logic       overflow;
    logic       last;
  } sap_res_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  pid;
    logic [15:0] xl, xh, yl, yh;
  } sap_cmd_t;

  typedef struct {
    logic signed [15:0] val;
    bit                 is_min;
    bit [2:0]           owner;
  } endpoint_t;

  // directed row: command, and an optional typed-in expectation
  typedef struct {
    sap_cmd_t c;
    bit       has_exp;
    sap_res_t exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [2:0]  in_particle_id = '0;
  logic [15:0] in_x_low = '0, in_x_high = '0, in_y_low = '0, in_y_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_assigned_id;
  logic        out_pair_valid;
  logic [2:0]  out_first_id;
  logic [2:0]  out_second_id;
  logic        out_overflow;
  logic        out_last;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sweep_and_prune_broadphase_unit u_dut (.*);

  always #1 clk = ~clk;

  // predictor state
  endpoint_t xs[NEND], ys[NEND];
  bit        x_ovl[NBOX*NBOX], y_ovl[NBOX*NBOX];
  int        box_count;
  bit        paused_q;
  sap_res_t  expected_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        stall_rand = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // append one expected result
  task automatic queue_expected(input sap_res_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  function automatic sap_res_t mk_res(logic [1:0] st, logic [2:0] id);
    sap_res_t r;
    r = '0;
    r.status = st;
    r.assigned_id = id;
    r.last = 1'b1;
    return r;
  endfunction

  // insertion sort of one axis, tracking overlap bits and new pairs
  task automatic sort_axis(bit is_y, inout sap_res_t pairs[$], inout bit over);
    endpoint_t key, oth;
    int        idx, s, n;
    n = 2 * box_count;
    for (int k = 1; k < n; k++) begin
      s = k;
      while (s > 0 && (is_y ? ys[s-1].val >= ys[s].val : xs[s-1].val >= xs[s].val)) begin
        key = is_y ? ys[s] : xs[s];
        oth = is_y ? ys[s-1] : xs[s-1];
        if (key.owner != oth.owner) begin
          idx = (key.owner < oth.owner) ? key.owner * NBOX + oth.owner
                                        : oth.owner * NBOX + key.owner;
          if (key.is_min && !oth.is_min) begin
            if (is_y) y_ovl[idx] = 1'b1; else x_ovl[idx] = 1'b1;
            if (x_ovl[idx] && y_ovl[idx]) begin
              if (pairs.size() < RESULT_LIMIT) begin
                sap_res_t r;
                r = '0;
                r.pair_valid = 1'b1;
                r.first_id = key.owner;
                r.second_id = oth.owner;
                pairs.insert(pairs.size(), r);
              end else over = 1'b1;
            end
          end
          if (!key.is_min && oth.is_min) begin
            if (is_y) y_ovl[idx] = 1'b0; else x_ovl[idx] = 1'b0;
          end
        end
        if (is_y) begin ys[s-1] = key; ys[s] = oth; end
        else begin xs[s-1] = key; xs[s] = oth; end
        s--;
      end
    end
  endtask

  // predict results of one accepted transaction
  task automatic predict_broadphase(input sap_cmd_t c);
    sap_res_t pairs[$];
    bit       over;
    int       b;
    over = 1'b0;
    case (c.cmd)
      CMD_CLEAR: begin
        box_count = 0;
        foreach (x_ovl[i]) begin x_ovl[i] = 0; y_ovl[i] = 0; end
        queue_expected(mk_res(ST_DONE, 0));
      end
      CMD_ADD: begin
        if (paused_q || box_count >= NBOX) queue_expected(mk_res(ST_REFUSED, 0));
        else begin
          b = 2 * box_count;
          xs[b] = '{c.xl, 1'b1, box_count[2:0]};
          xs[b+1] = '{c.xh, 1'b0, box_count[2:0]};
          ys[b] = '{c.yl, 1'b1, box_count[2:0]};
          ys[b+1] = '{c.yh, 1'b0, box_count[2:0]};
          queue_expected(mk_res(ST_DONE, box_count[2:0]));
          box_count++;
        end
      end
      CMD_UPDATE: begin
        if (c.pid >= box_count) queue_expected(mk_res(ST_BAD_ID, 0));
        else begin
          for (int k = 0; k < 2 * box_count; k++) begin
            if (xs[k].owner == c.pid) xs[k].val = xs[k].is_min ? c.xl : c.xh;
            if (ys[k].owner == c.pid) ys[k].val = ys[k].is_min ? c.yl : c.yh;
          end
          queue_expected(mk_res(ST_DONE, 0));
        end
      end
      default: begin
        sort_axis(1'b0, pairs, over);
        sort_axis(1'b1, pairs, over);
        if (pairs.size() == 0) queue_expected(mk_res(ST_DONE, 0));
        else begin
          pairs[$].last = 1'b1;
          pairs[$].overflow = over;
          foreach (pairs[i]) queue_expected(pairs[i]);
        end
      end
    endcase
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      sap_res_t got, exp;
      got = '{out_status, out_assigned_id, out_pair_valid, out_first_id, out_second_id,
              out_overflow, out_last};
      if (expected_q.size() == 0) report_mismatch($sformatf("unexpected result %h", got));
      else begin
        exp = expected_q[0];
        expected_q.delete(0);
        if (got.status != exp.status)
          report_mismatch($sformatf("status %0d exp %0d", got.status, exp.status));
        if (got.assigned_id != exp.assigned_id)
          report_mismatch($sformatf("assigned_id %0d exp %0d", got.assigned_id, exp.assigned_id));
        if (got.pair_valid != exp.pair_valid)
          report_mismatch($sformatf("pair_valid %0d exp %0d", got.pair_valid, exp.pair_valid));
        if (got.first_id != exp.first_id)
          report_mismatch($sformatf("first_id %0d exp %0d", got.first_id, exp.first_id));
        if (got.second_id != exp.second_id)
          report_mismatch($sformatf("second_id %0d exp %0d", got.second_id, exp.second_id));
        if (got.overflow != exp.overflow)
          report_mismatch($sformatf("overflow %0d exp %0d", got.overflow, exp.overflow));
        if (got.last != exp.last)
          report_mismatch($sformatf("last %0d exp %0d", got.last, exp.last));
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long
  always @(negedge clk) begin
    if (!stall_rand) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(5, 40);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // idle the input for a random gap; a zero gap keeps valid high for the next transaction
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // one transaction; optional typed-in expectation
  task automatic send_cmd(input sap_cmd_t c, input bit has_exp, input sap_res_t exp);
    int base_idx;
    in_valid <= 1'b1;
    in_cmd <= c.cmd;
    in_particle_id <= c.pid;
    in_x_low <= c.xl; in_x_high <= c.xh; in_y_low <= c.yl; in_y_high <= c.yh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    base_idx = expected_q.size();
    predict_broadphase(c);
    if (has_exp && expected_q[base_idx] != exp)
      report_mismatch($sformatf("predictor disagrees with table row cmd %0d", c.cmd));
    @(negedge clk);
    sender_gap();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_paused(input bit v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {REG_PAUSED, 2'b00}; pwdata <= {31'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    paused_q = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic sap_cmd_t mk_cmd(cmd_t c, logic [2:0] p, logic [15:0] a, logic [15:0] b,
                                      logic [15:0] d, logic [15:0] e);
    return '{c, p, a, b, d, e};
  endfunction

  // random box, mostly small overlapping coordinates, sometimes full range
  function automatic sap_cmd_t rand_box(cmd_t c);
    sap_cmd_t r;
    logic signed [15:0] lo;
    r.cmd = c;
    r.pid = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 7) == 0) begin
      r.xl = 16'($urandom); r.xh = 16'($urandom); r.yl = 16'($urandom); r.yh = 16'($urandom);
    end else begin
      lo = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      r.xl = lo; r.xh = lo + 16'($urandom_range(0, 60));
      lo = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      r.yl = lo; r.yh = lo + 16'($urandom_range(0, 60));
    end
    return r;
  endfunction

  dir_row_t dir_rows[$];

  // append one directed row
  task automatic append_row(input sap_cmd_t c, input bit has_exp, input sap_res_t exp);
    dir_row_t row;
    row.c = c;
    row.has_exp = has_exp;
    row.exp = exp;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    sap_res_t none;
    sap_cmd_t c;
    int sent;
    none = '0;
    box_count = 0;
    paused_q = 1'b0;
    foreach (x_ovl[i]) begin x_ovl[i] = 0; y_ovl[i] = 0; end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, refusals, bad id, ties
    append_row(mk_cmd(CMD_SWEEP, 0, 0, 0, 0, 0), 1, mk_res(ST_DONE, 0));
    append_row(mk_cmd(CMD_UPDATE, 0, 0, 0, 0, 0), 1, mk_res(ST_BAD_ID, 0));
    append_row(mk_cmd(CMD_ADD, 7, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff), 1,
               mk_res(ST_DONE, 0));
    append_row(mk_cmd(CMD_ADD, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000), 1,
               mk_res(ST_DONE, 1));
    append_row(mk_cmd(CMD_ADD, 0, 5, 5, 5, 5), 1, mk_res(ST_DONE, 2));
    append_row(mk_cmd(CMD_ADD, 0, 5, 10, 5, 10), 1, mk_res(ST_DONE, 3));
    append_row(mk_cmd(CMD_SWEEP, 0, 0, 0, 0, 0), 0, none);
    append_row(mk_cmd(CMD_UPDATE, 1, 0, 0, 0, 0), 0, none);
    append_row(mk_cmd(CMD_UPDATE, 3, 16'hffff, 16'h5555, 16'haaaa, 16'h0001), 0, none);
    append_row(mk_cmd(CMD_UPDATE, 4, 0, 0, 0, 0), 1, mk_res(ST_BAD_ID, 0));
    append_row(mk_cmd(CMD_SWEEP, 0, 0, 0, 0, 0), 0, none);
    for (int i = 0; i < 4; i++)
      append_row(mk_cmd(CMD_ADD, 0, 0, 100, 0, 100), 1, mk_res(ST_DONE, 3'(4 + i)));
    append_row(mk_cmd(CMD_ADD, 0, 0, 0, 0, 0), 1, mk_res(ST_REFUSED, 0));
    append_row(mk_cmd(CMD_SWEEP, 0, 0, 0, 0, 0), 0, none);
    append_row(mk_cmd(CMD_UPDATE, 7, 200, 300, 200, 300), 0, none);
    append_row(mk_cmd(CMD_SWEEP, 0, 0, 0, 0, 0), 0, none);
    append_row(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0), 1, mk_res(ST_DONE, 0));
    append_row(mk_cmd(CMD_SWEEP, 0, 0, 0, 0, 0), 1, mk_res(ST_DONE, 0));
    foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].has_exp, dir_rows[i].exp);
    drain_results();

    // paused: add refused, clear keeps the flag
    write_paused(1'b1);
    send_cmd(mk_cmd(CMD_ADD, 0, 1, 2, 3, 4), 1, mk_res(ST_REFUSED, 0));
    send_cmd(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 0), 1, mk_res(ST_DONE, 0));
    send_cmd(mk_cmd(CMD_ADD, 0, 1, 2, 3, 4), 1, mk_res(ST_REFUSED, 0));
    drain_results();
    write_paused(1'b0);

    // random: fill, jiggle with updates and sweeps, clear now and then
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      stall_rand = (phase != 2);
      while (sent < 80 * (phase + 1)) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) c = mk_cmd(CMD_CLEAR, 0, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
        else if (r < 25) c = rand_box(CMD_ADD);
        else if (r < 65) c = rand_box(CMD_UPDATE);
        else c = rand_box(CMD_SWEEP);
        send_cmd(c, 1'b0, none);
        sent++;
      end
      drain_results();
      if (phase == 1) write_paused(1'b1);
      if (phase == 2) write_paused(1'b0);
    end

    drain_results();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
